@@ hdl/flow_hash_queue_steering_assert.svh @@
// ----------------------------------------------------------------------------
// Flow hash steering assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FLOW_HASH_QUEUE_STEERING_ASSERT_SVH
`define FLOW_HASH_QUEUE_STEERING_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define FHQS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define FHQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fhqs_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow hash steering package
// Shared widths, protocol constants, codes and structs.
// ----------------------------------------------------------------------------
package fhqs_pkg;

    // Widths
    localparam int HASH_W  = 32;
    localparam int CNT_W   = 64;
    localparam int SLOT_W  = 3;
    localparam int MASK_W  = 5;
    localparam int OFF_W   = 7;
    localparam int LEN_W   = OFF_W + 1;
    localparam int CFG_W   = 16;
    localparam int NIB_W   = 4;
    localparam int NIBBLES = HASH_W / NIB_W;
    localparam int QUEUE_DEPTH = 4;

    // Frame offsets and lengths
    localparam logic [OFF_W-1:0] OFF_ETYPE_HI     = 7'd12;
    localparam logic [OFF_W-1:0] OFF_ETYPE_LO     = 7'd13;
    localparam logic [OFF_W-1:0] OFF_L3           = 7'd14;
    localparam logic [OFF_W-1:0] OFF_PROTO        = 7'd23;
    localparam logic [OFF_W-1:0] OFF_ADDR_FIRST   = 7'd26;
    localparam logic [OFF_W-1:0] OFF_ADDR_LAST    = 7'd33;
    localparam logic [OFF_W-1:0] OFF_PAYLOAD_LAST = 7'd21;
    localparam logic [OFF_W-1:0] OFF_MAX          = 7'd127;
    localparam logic [LEN_W-1:0] PORT_BYTES       = 8'd4;
    localparam logic [LEN_W-1:0] MIN_ETH_LEN      = 8'd14;
    localparam logic [LEN_W-1:0] MIN_V4_LEN       = 8'd34;
    localparam logic [LEN_W-1:0] LEN_ONE_WORD     = 8'd18;
    localparam logic [LEN_W-1:0] LEN_TWO_WORDS    = 8'd22;

    // Protocol values
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    // Finalizer constants
    localparam logic [HASH_W-1:0] FMIX_C1 = 32'h85EBCA6B;
    localparam logic [HASH_W-1:0] FMIX_C2 = 32'hC2B2AE35;
    localparam int FMIX_SH_A = 16;
    localparam int FMIX_SH_B = 13;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TUNNEL_V4 = 2'd0,
        REG_TUNNEL_V6 = 2'd1,
        REG_SLOT_MASK = 2'd2
    } fhqs_reg_t;

    // Frame class decided by the parser
    typedef enum logic [1:0] {
        CLS_SHORT = 2'd0,
        CLS_NONIP = 2'd1,
        CLS_HASH  = 2'd2
    } fhqs_cls_t;

    // Reported outcome
    typedef enum logic [1:0] {
        OUT_REDIRECT = 2'd0,
        OUT_TRUNC    = 2'd1,
        OUT_NONIP    = 2'd2,
        OUT_UNBOUND  = 2'd3
    } fhqs_outcome_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_MOD,
        ST_DONE
    } fhqs_state_t;

    typedef struct packed {
        logic [15:0]       tunnel_v4;
        logic [15:0]       tunnel_v6;
        logic [MASK_W-1:0] bound_mask;
    } fhqs_cfg_t;

    typedef struct packed {
        fhqs_cls_t         cls;
        logic [HASH_W-1:0] hash;
    } fhqs_desc_t;

endpackage

@@ hdl/fhqs_chan_if.sv @@
// ----------------------------------------------------------------------------
// Flow hash steering channels
// Valid/ready channels for frame bytes and steering results.
// ----------------------------------------------------------------------------
interface fhqs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface fhqs_result_if;
    logic                         valid;
    logic                         ready;
    logic                         verdict;
    logic [fhqs_pkg::SLOT_W-1:0]  slot;
    logic [1:0]                   outcome;
    logic [fhqs_pkg::CNT_W-1:0]   frames_seen;
    logic [fhqs_pkg::CNT_W-1:0]   non_ip_seen;
    logic [fhqs_pkg::CNT_W-1:0]   redirected_seen;
    logic [fhqs_pkg::CNT_W-1:0]   unbound_seen;

    modport source (output valid, output verdict, output slot, output outcome,
                    output frames_seen, output non_ip_seen, output redirected_seen,
                    output unbound_seen, input ready);
    modport sink (input valid, input verdict, input slot, input outcome,
                  input frames_seen, input non_ip_seen, input redirected_seen,
                  input unbound_seen, output ready);
endinterface

@@ hdl/fhqs_parse.sv @@
// ----------------------------------------------------------------------------
// Flow hash steering frame parser
// Takes one byte per beat, collects header fields and, on the last byte,
// classifies the frame and pushes a descriptor with its raw flow hash.
// ----------------------------------------------------------------------------
module fhqs_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fhqs_pkg::fhqs_cfg_t  cfg,
    fhqs_byte_if.sink            frame_in,
    input  logic                 q_full,
    output logic                 q_push,
    output fhqs_pkg::fhqs_desc_t q_desc
);

    logic [fhqs_pkg::OFF_W-1:0]  off_reg, off_next;
    logic [15:0]                 etype_reg, etype_next;
    logic [3:0]                  ihl_reg, ihl_next;
    logic [7:0]                  proto_reg, proto_next;
    logic [fhqs_pkg::HASH_W-1:0] addr_reg, addr_next;
    logic [fhqs_pkg::HASH_W-1:0] port_reg, port_next;
    logic [1:0][fhqs_pkg::HASH_W-1:0] pw_reg, pw_next;

    logic                        accept;
    logic [7:0]                  b;
    logic [fhqs_pkg::OFF_W-1:0]  addr_rel;
    logic [fhqs_pkg::OFF_W-1:0]  pay_rel;
    logic [fhqs_pkg::OFF_W-1:0]  trans;
    logic [fhqs_pkg::OFF_W-1:0]  port_rel;
    logic [fhqs_pkg::LEN_W-1:0]  len;
    logic                        is_v4;
    logic                        is_v6;
    logic                        tun_v4;
    logic                        tun_v6;
    logic                        port_ok;

    // Take bytes whenever the queue can hold a descriptor
    assign frame_in.ready = !q_full;
    assign accept         = frame_in.valid && frame_in.ready;
    assign b              = frame_in.frame_byte;

    assign addr_rel = off_reg - fhqs_pkg::OFF_ADDR_FIRST;
    assign pay_rel  = off_reg - fhqs_pkg::OFF_L3;
    assign len      = {1'b0, off_reg} + 8'd1;

    // Fold this byte into the frame fields
    always_comb
    begin
        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        addr_next  = addr_reg;
        pw_next    = pw_reg;
        port_next  = port_reg;
        if (off_reg == fhqs_pkg::OFF_ETYPE_HI)
            etype_next[15:8] = b;
        if (off_reg == fhqs_pkg::OFF_ETYPE_LO)
            etype_next[7:0] = b;
        if (off_reg == fhqs_pkg::OFF_L3)
            ihl_next = b[3:0];
        if (off_reg == fhqs_pkg::OFF_PROTO)
            proto_next = b;
        if (off_reg >= fhqs_pkg::OFF_ADDR_FIRST && off_reg <= fhqs_pkg::OFF_ADDR_LAST)
            addr_next = addr_reg ^ (32'(b) << {addr_rel[1:0], 3'b000});
        if (off_reg >= fhqs_pkg::OFF_L3 && off_reg <= fhqs_pkg::OFF_PAYLOAD_LAST)
            pw_next[pay_rel[2]] = pw_reg[pay_rel[2]] | (32'(b) << {pay_rel[1:0], 3'b000});
        // Transport header follows the IPv4 header
        trans    = fhqs_pkg::OFF_L3 + {1'b0, ihl_next, 2'b00};
        port_rel = off_reg - trans;
        if (off_reg >= trans && port_rel[fhqs_pkg::OFF_W-1:2] == '0)
            port_next = port_reg | (32'(b) << {~port_rel[1], port_rel[0], 3'b000});
        off_next = (off_reg == fhqs_pkg::OFF_MAX) ? off_reg : off_reg + 7'd1;
    end

    // Classify the frame and pick the hash input
    always_comb
    begin
        is_v4   = etype_next == fhqs_pkg::ETH_TYPE_IPV4;
        is_v6   = etype_next == fhqs_pkg::ETH_TYPE_IPV6;
        tun_v4  = cfg.tunnel_v4 != '0 && cfg.tunnel_v4[15:8] == etype_next[15:8];
        tun_v6  = cfg.tunnel_v6 != '0 && cfg.tunnel_v6[15:8] == etype_next[15:8];
        port_ok = (proto_next == fhqs_pkg::PROTO_TCP || proto_next == fhqs_pkg::PROTO_UDP)
                  && len >= ({1'b0, trans} + fhqs_pkg::PORT_BYTES);
        q_desc.cls  = fhqs_pkg::CLS_HASH;
        q_desc.hash = '0;
        if (len < fhqs_pkg::MIN_ETH_LEN)
            q_desc.cls = fhqs_pkg::CLS_SHORT;
        else if (!is_v4 && !is_v6 && !tun_v4 && !tun_v6)
            q_desc.cls = fhqs_pkg::CLS_NONIP;
        else if (is_v4 && len < fhqs_pkg::MIN_V4_LEN)
            q_desc.cls = fhqs_pkg::CLS_SHORT;
        else if (is_v4)
            q_desc.hash = port_ok ? (addr_next ^ port_next) : addr_next;
        else if (len >= fhqs_pkg::LEN_TWO_WORDS)
            q_desc.hash = pw_next[0] ^ pw_next[1];
        else if (len >= fhqs_pkg::LEN_ONE_WORD)
            q_desc.hash = pw_next[0];
    end

    assign q_push = accept && frame_in.frame_last;

    // Advance the frame state; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            etype_reg <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            addr_reg  <= '0;
            port_reg  <= '0;
            pw_reg    <= '0;
        end
        else if (accept)
        begin
            if (frame_in.frame_last)
            begin
                off_reg   <= '0;
                etype_reg <= '0;
                ihl_reg   <= '0;
                proto_reg <= '0;
                addr_reg  <= '0;
                port_reg  <= '0;
                pw_reg    <= '0;
            end
            else
            begin
                off_reg   <= off_next;
                etype_reg <= etype_next;
                ihl_reg   <= ihl_next;
                proto_reg <= proto_next;
                addr_reg  <= addr_next;
                port_reg  <= port_next;
                pw_reg    <= pw_next;
            end
        end
    end

endmodule

@@ hdl/fhqs_fifo.sv @@
// ----------------------------------------------------------------------------
// Flow hash steering descriptor queue
// Small first-in first-out queue between the parser and the hash engine.
// ----------------------------------------------------------------------------
module fhqs_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fhqs_pkg::fhqs_desc_t wr_data,
    input  logic                 pop,
    output fhqs_pkg::fhqs_desc_t rd_data,
    output logic                 full,
    output logic                 empty
);

    localparam int DEPTH = fhqs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fhqs_pkg::fhqs_desc_t slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Store a descriptor
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ hdl/fhqs_hash.sv @@
// ----------------------------------------------------------------------------
// Flow hash steering hash engine
// Runs the 32-bit finalizer on one shared multiplier, reduces the hash
// modulo the slot count a nibble per cycle, updates the counters and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module fhqs_hash #(
    parameter int unsigned SLOTS = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fhqs_pkg::fhqs_cfg_t  cfg,
    input  logic                 q_empty,
    input  fhqs_pkg::fhqs_desc_t q_desc,
    output logic                 q_pop,
    fhqs_result_if.source        result
);

    localparam int SW    = fhqs_pkg::SLOT_W;
    localparam int NCNT_W = $clog2(fhqs_pkg::NIBBLES);
    localparam logic [SW:0] SLOTS_EXT = (SW + 1)'(SLOTS);

    fhqs_pkg::fhqs_state_t       state_reg, state_next;
    fhqs_pkg::fhqs_cls_t         cls_reg;
    logic [fhqs_pkg::HASH_W-1:0] h_reg;
    logic [SW-1:0]               rem_reg;
    logic [NCNT_W-1:0]           nib_reg;

    logic [fhqs_pkg::CNT_W-1:0]  total_reg, nonip_reg, redir_reg, unbound_reg;
    logic [fhqs_pkg::CNT_W-1:0]  total_next, nonip_next, redir_next, unbound_next;

    logic                        out_valid_reg;
    logic                        out_verdict_reg;
    logic [SW-1:0]               out_slot_reg;
    fhqs_pkg::fhqs_outcome_t     out_outcome_reg;
    logic [fhqs_pkg::CNT_W-1:0]  out_total_reg, out_nonip_reg, out_redir_reg, out_unbound_reg;

    logic [fhqs_pkg::HASH_W-1:0] mul_k;
    logic [fhqs_pkg::HASH_W-1:0] mul_lo;
    logic [(2*fhqs_pkg::MASK_W)-1:0] mask_ext;
    logic                        bound;
    logic                        out_load;
    logic                        mod_last;
    logic                        verdict_next;
    fhqs_pkg::fhqs_outcome_t     outcome_next;

    // Reduce a running remainder by one nibble, one bit per step
    function automatic logic [SW-1:0] mod_nibble(input logic [SW-1:0] rem,
                                                 input logic [fhqs_pkg::NIB_W-1:0] nib);
        logic [SW:0]   t;
        logic [SW-1:0] r;
        r = rem;
        for (int i = fhqs_pkg::NIB_W - 1; i >= 0; i--)
        begin
            t = {r, nib[i]};
            if (t >= SLOTS_EXT)
                t = t - SLOTS_EXT;
            r = t[SW-1:0];
        end
        return r;
    endfunction

    // Shared multiplier, low word only
    assign mul_k  = (state_reg == fhqs_pkg::ST_MIX1) ? fhqs_pkg::FMIX_C1 : fhqs_pkg::FMIX_C2;
    assign mul_lo = h_reg * mul_k;

    assign mod_last = nib_reg == NCNT_W'(fhqs_pkg::NIBBLES - 1);
    assign mask_ext = {{fhqs_pkg::MASK_W{1'b0}}, cfg.bound_mask};
    assign bound    = {1'b0, rem_reg} < (SW + 1)'(fhqs_pkg::MASK_W)
                      && mask_ext[rem_reg];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fhqs_pkg::ST_IDLE:
                if (!q_empty)
                    state_next = (q_desc.cls == fhqs_pkg::CLS_HASH) ?
                                 fhqs_pkg::ST_MIX1 : fhqs_pkg::ST_DONE;
            fhqs_pkg::ST_MIX1:
                state_next = fhqs_pkg::ST_MIX2;
            fhqs_pkg::ST_MIX2:
                state_next = fhqs_pkg::ST_MOD;
            fhqs_pkg::ST_MOD:
                if (mod_last)
                    state_next = fhqs_pkg::ST_DONE;
            fhqs_pkg::ST_DONE:
                if (out_load)
                    state_next = fhqs_pkg::ST_IDLE;
            default:
                state_next = fhqs_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        q_pop    = (state_reg == fhqs_pkg::ST_IDLE) && !q_empty;
        out_load = (state_reg == fhqs_pkg::ST_DONE) && (!out_valid_reg || result.ready);
    end

    // Verdict and counter updates for the finished frame
    always_comb
    begin
        verdict_next = 1'b0;
        total_next   = total_reg + 64'd1;
        nonip_next   = nonip_reg;
        redir_next   = redir_reg;
        unbound_next = unbound_reg;
        case (cls_reg)
            fhqs_pkg::CLS_SHORT:
                outcome_next = fhqs_pkg::OUT_TRUNC;
            fhqs_pkg::CLS_NONIP:
            begin
                outcome_next = fhqs_pkg::OUT_NONIP;
                nonip_next   = nonip_reg + 64'd1;
            end
            fhqs_pkg::CLS_HASH:
                if (bound)
                begin
                    outcome_next = fhqs_pkg::OUT_REDIRECT;
                    verdict_next = 1'b1;
                    redir_next   = redir_reg + 64'd1;
                end
                else
                begin
                    outcome_next = fhqs_pkg::OUT_UNBOUND;
                    unbound_next = unbound_reg + 64'd1;
                end
            default:
                outcome_next = fhqs_pkg::OUT_TRUNC;
        endcase
    end

    // Control state, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fhqs_pkg::ST_IDLE;
            total_reg     <= '0;
            nonip_reg     <= '0;
            redir_reg     <= '0;
            unbound_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                total_reg     <= total_next;
                nonip_reg     <= nonip_next;
                redir_reg     <= redir_next;
                unbound_reg   <= unbound_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hash datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fhqs_pkg::ST_IDLE:
            begin
                cls_reg <= q_desc.cls;
                h_reg   <= q_desc.hash ^ (q_desc.hash >> fhqs_pkg::FMIX_SH_A);
                rem_reg <= '0;
                nib_reg <= '0;
            end
            fhqs_pkg::ST_MIX1:
                h_reg <= mul_lo ^ (mul_lo >> fhqs_pkg::FMIX_SH_B);
            fhqs_pkg::ST_MIX2:
                h_reg <= mul_lo ^ (mul_lo >> fhqs_pkg::FMIX_SH_A);
            fhqs_pkg::ST_MOD:
            begin
                rem_reg <= mod_nibble(rem_reg,
                                      h_reg[fhqs_pkg::HASH_W-1 -: fhqs_pkg::NIB_W]);
                h_reg   <= h_reg << fhqs_pkg::NIB_W;
                nib_reg <= nib_reg + 1'b1;
            end
            default:
                h_reg <= h_reg;
        endcase
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_verdict_reg <= verdict_next;
            out_slot_reg    <= rem_reg;
            out_outcome_reg <= outcome_next;
            out_total_reg   <= total_next;
            out_nonip_reg   <= nonip_next;
            out_redir_reg   <= redir_next;
            out_unbound_reg <= unbound_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.verdict         = out_verdict_reg;
    assign result.slot            = out_slot_reg;
    assign result.outcome         = out_outcome_reg;
    assign result.frames_seen     = out_total_reg;
    assign result.non_ip_seen     = out_nonip_reg;
    assign result.redirected_seen = out_redir_reg;
    assign result.unbound_seen    = out_unbound_reg;

endmodule

@@ hdl/flow_hash_queue_steering.sv @@
// Sequence: a hashed frame's descriptor goes through the queue, ST_IDLE, ST_MIX1, ST_MIX2,
// ST_MOD and ST_DONE to the result register; short and non-IP frames skip MIX and MOD.
// Throughput: one byte per cycle while the 4-entry descriptor queue has room;
// the hash engine takes the next descriptor only after the last result is loaded.
// Reset: rst_n asynchronously clears the frame state, counters and control registers.
// ----------------------------------------------------------------------------
// Flow hash queue steering
// Parses Ethernet frames byte by byte, hashes the flow and steers the frame
// to its slot when that slot is bound; keeps wrapping frame counters.
// ----------------------------------------------------------------------------
`include "flow_hash_queue_steering_assert.svh"

module flow_hash_queue_steering #(
    parameter int unsigned SLOTS = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [fhqs_pkg::CFG_W-1:0]  cfg_data,
    fhqs_byte_if.sink                   frame_in,
    fhqs_result_if.source               result
);

    fhqs_pkg::fhqs_cfg_t  cfg_reg;
    fhqs_pkg::fhqs_desc_t push_desc;
    fhqs_pkg::fhqs_desc_t pop_desc;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                fhqs_pkg::REG_TUNNEL_V4:
                    cfg_reg.tunnel_v4 <= cfg_data;
                fhqs_pkg::REG_TUNNEL_V6:
                    cfg_reg.tunnel_v6 <= cfg_data;
                fhqs_pkg::REG_SLOT_MASK:
                    cfg_reg.bound_mask <= cfg_data[fhqs_pkg::MASK_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    fhqs_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .frame_in (frame_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (push_desc)
    );

    fhqs_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_desc),
        .pop     (q_pop),
        .rd_data (pop_desc),
        .full    (q_full),
        .empty   (q_empty)
    );

    fhqs_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_desc  (pop_desc),
        .q_pop   (q_pop),
        .result  (result)
    );

    // Checks
    `FHQS_ASSERT_IMPL(a_no_overflow, clk, rst_n, q_push, !q_full, "descriptor pushed into full queue")
    `FHQS_ASSERT_IMPL(a_no_underflow, clk, rst_n, q_pop, !q_empty, "descriptor popped from empty queue")
    `FHQS_ASSERT_NEXT(a_push_visible, clk, rst_n, q_push, !q_empty, "pushed descriptor not visible")
    `FHQS_ASSERT_IMPL(a_verdict_match, clk, rst_n, result.valid, result.verdict == (result.outcome == fhqs_pkg::OUT_REDIRECT), "verdict disagrees with outcome")

endmodule
